[design/gha_pkg.sv]
// Types, constants and codes shared by the generational handle allocator.
package gha_pkg;

	localparam int MAX_SLOTS = 4096;
	localparam int GEN_BITS  = 32;
	localparam int IDX_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W     = IDX_W + 1;

	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_QUERY   = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic [GEN_BITS-1:0] INITIAL_LIVE_GEN = GEN_BITS'(1);

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [GEN_BITS-1:0] gen_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] handle_index;
		logic [31:0] handle_generation;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] granted_index;
		logic [31:0] granted_generation;
		logic        alive;
	} rsp_t;

	typedef struct packed {
		logic gen_we;
		logic link_we;
		idx_t addr;
		gen_t gen;
		cnt_t link;
	} store_wr_t;

endpackage

[design/gha_req_if.sv]
// Request channel: valid, ready and the request payload.
interface gha_req_if;
	logic          valid;
	logic          ready;
	gha_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/gha_rsp_if.sv]
// Response channel: valid, ready and the result payload.
interface gha_rsp_if;
	logic          valid;
	logic          ready;
	gha_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/gha_store.sv]
// Generation and free-link memories with one registered read port each.
module gha_store (
	input  logic                clk,
	input  logic                rd_en,
	input  gha_pkg::idx_t       rd_addr,
	input  gha_pkg::store_wr_t  wr,
	output gha_pkg::gen_t       rd_gen,
	output gha_pkg::cnt_t       rd_link
);

	gha_pkg::gen_t gen_mem [gha_pkg::MAX_SLOTS];
	gha_pkg::cnt_t link_mem [gha_pkg::MAX_SLOTS];

	always_ff @(posedge clk) begin
		if (wr.gen_we) begin
			gen_mem[wr.addr] <= wr.gen;
		end
		if (wr.link_we) begin
			link_mem[wr.addr] <= wr.link;
		end
		if (rd_en) begin
			rd_gen  <= gen_mem[rd_addr];
			rd_link <= link_mem[rd_addr];
		end
	end

endmodule

[design/generational_handle_allocator.sv]
// Top level of the generational handle allocator: control, counters and response register.
//
//   channel | modport | handshake    | payload
//   req     | sink    | valid/ready  | cmd, handle_index, handle_generation
//   rsp     | source  | valid/ready  | status, granted_index, granted_generation, alive
//
// A request is taken in the idle state, where the generation and link memories are read;
// the execute state then decides, writes back and loads the response register.
// The registered read port of the memories calls for this split; no clearing pass is
// needed after reset, since slots at or above the fresh count read as generation zero.
// A request is taken only in the idle state; a response that is not taken holds
// the block in its execute state, and ready stays low until it leaves.
module generational_handle_allocator (
	input  logic      clk,
	input  logic      arst_n,
	gha_req_if.sink   req,
	gha_rsp_if.source rsp
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t             state_q;
	gha_pkg::req_t      req_s1;
	gha_pkg::idx_t      rd_addr_s1;
	gha_pkg::cnt_t      free_top_q;
	gha_pkg::cnt_t      fresh_q;
	gha_pkg::rsp_t      rsp_q;
	logic               rsp_valid_q;

	logic               rd_en;
	gha_pkg::idx_t      rd_addr;
	gha_pkg::gen_t      rd_gen;
	gha_pkg::cnt_t      rd_link;
	gha_pkg::store_wr_t wr;

	logic               done;
	logic               in_range;
	gha_pkg::gen_t      gen_eff;
	logic               gen_match;
	gha_pkg::gen_t      gen_inc;
	gha_pkg::rsp_t      rsp_d;
	gha_pkg::cnt_t      free_top_d;
	gha_pkg::cnt_t      fresh_d;

	assign req.ready = (state_q == S_IDLE);
	assign rd_en     = req.valid && req.ready;
	assign rd_addr   = (req.data.cmd == gha_pkg::CMD_CREATE) ?
		free_top_q[gha_pkg::IDX_W-1:0] : req.data.handle_index[gha_pkg::IDX_W-1:0];

	gha_store u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_gen  (rd_gen),
		.rd_link (rd_link)
	);

	assign done      = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);
	assign in_range  = req_s1.handle_index < 32'(gha_pkg::MAX_SLOTS);
	assign gen_eff   = (gha_pkg::CNT_W'(rd_addr_s1) < fresh_q) ? rd_gen : '0;
	assign gen_match = in_range && gen_eff[0] && (32'(gen_eff) == req_s1.handle_generation);
	assign gen_inc   = gen_eff + gha_pkg::GEN_BITS'(1);

	always_comb begin
		rsp_d      = '0;
		free_top_d = free_top_q;
		fresh_d    = fresh_q;
		wr         = '0;
		wr.addr    = rd_addr_s1;
		wr.link    = free_top_q;
		case (req_s1.cmd)
			gha_pkg::CMD_CREATE: begin
				if (!free_top_q[gha_pkg::IDX_W]) begin
					wr.gen_we                = done;
					wr.gen                   = gen_inc;
					free_top_d               = (rd_link > gha_pkg::CNT_W'(gha_pkg::MAX_SLOTS)) ?
						gha_pkg::CNT_W'(gha_pkg::MAX_SLOTS) : rd_link;
					rsp_d.granted_index      = 12'(rd_addr_s1);
					rsp_d.granted_generation = 32'(gen_inc);
				end else if (!fresh_q[gha_pkg::IDX_W]) begin
					wr.gen_we                = done;
					wr.addr                  = fresh_q[gha_pkg::IDX_W-1:0];
					wr.gen                   = gha_pkg::INITIAL_LIVE_GEN;
					fresh_d                  = fresh_q + gha_pkg::CNT_W'(1);
					rsp_d.granted_index      = 12'(fresh_q[gha_pkg::IDX_W-1:0]);
					rsp_d.granted_generation = 32'(gha_pkg::INITIAL_LIVE_GEN);
				end else begin
					rsp_d.status = gha_pkg::ST_FULL;
				end
			end
			gha_pkg::CMD_DESTROY: begin
				if (gen_match) begin
					wr.gen_we  = done;
					wr.link_we = done;
					wr.gen     = gen_inc;
					free_top_d = gha_pkg::CNT_W'(rd_addr_s1);
				end else begin
					rsp_d.status = gha_pkg::ST_IGNORED;
				end
			end
			gha_pkg::CMD_QUERY: begin
				rsp_d.alive = gen_match;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_top_q  <= gha_pkg::CNT_W'(gha_pkg::MAX_SLOTS);
			fresh_q     <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && !done) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (rd_en) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						state_q     <= S_IDLE;
						free_top_q  <= free_top_d;
						fresh_q     <= fresh_d;
						rsp_q       <= rsp_d;
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			req_s1     <= req.data;
			rd_addr_s1 <= rd_addr;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_EXEC))
		else $error("accepted request did not enter execute");

	a_fresh_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (fresh_q >= $past(fresh_q)))
		else $error("fresh count decreased");

	a_top_below_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		!free_top_q[gha_pkg::IDX_W] |-> (free_top_q < fresh_q))
		else $error("free list top beyond fresh count");

	a_resp_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!rsp_valid_q || rsp.ready))
		else $error("response overwritten before taken");

endmodule
